/* hdl/apu_pkg.sv */
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types and constants for the dispersive polarization update block.
// ----------------------------------------------------------------------------
package apu_pkg;

   // Function codes carried in the item.
   localparam logic [1:0] FUNC_UPD_X = 2'd0;
   localparam logic [1:0] FUNC_UPD_Y = 2'd1;
   localparam logic [1:0] FUNC_UPD_Z = 2'd2;
   localparam logic [1:0] FUNC_LOAD  = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [0:0] REG_ACTIVE_POLES = 1'd0;
   localparam logic [0:0] REG_TOLERANCE    = 1'd1;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic        is_load;
      logic [1:0]  axis;
      logic [11:0] cell_idx;
      logic [2:0]  pole;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] wf;
      logic [31:0] flux;
      logic [31:0] field;
      logic [31:0] eps;
   } item_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_MUL,
      ST_SUM,
      ST_ACC,
      ST_DIV_START,
      ST_DIV,
      ST_DONE
   } back_state_type;

endpackage

/* hdl/ade_polarization_update.sv */
// ----------------------------------------------------------------------------
// ade_polarization_update
// Dispersive polarization update for an FDTD grid cell, Q16.16.
// ----------------------------------------------------------------------------
// Usage: items enter on req_ (tuser = func, tdata = the remaining fields) and
// one result per item leaves on rsp_. A load item writes one pole's three
// weights and answers with zeros. An update item steps through the read,
// multiply, sum and accumulate states per active pole over the weight and
// history memories (one read port each, one multiply stage), then, unless
// the permittivity is zero, a bit-serial divider; one item is in the sequencer
// at a time. A two-item queue sits ahead of the sequencer and the result
// register, so the input keeps taking items while a result waits, until the
// queue is full. After reset the history memories are cleared, one entry a
// cycle over 3*MAX_POLES*CELL_COUNT entries, and no item is taken until this
// ends. If rsp_tready is low the result holds and the sequencer waits in its
// final step; registers on csr_ may be written only while the block is idle.
// ----------------------------------------------------------------------------
module ade_polarization_update
   import apu_pkg::*;
#(
   parameter int MAX_POLES  = 8,
   parameter int CELL_COUNT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // fields from bit 0: cell_index[11:0], pole_number[14:12],
   // coef_history_one[46:15], coef_history_two[78:47], coef_field[110:79],
   // flux_value[142:111], field_value[174:143], permittivity[206:175]
   input  logic [207:0] req_tdata,
   // fields from bit 0: func[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fields from bit 0: new_field[31:0], cell_dispersive[32], divide_fault[33]
   output logic [39:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   item_type    in_item, q_item;
   logic        q_valid, q_ready;
   logic [3:0]  active_ff;
   logic [30:0] tol_ff;
   logic [31:0] field;
   logic        disp, fault;
   logic        wr_en;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         tol_ff    <= '0;
      end else if (wr_en && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == REG_ACTIVE_POLES) active_ff <= csr_pwdata[3:0];
         else tol_ff <= csr_pwdata[30:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == {REG_ACTIVE_POLES, 2'b00}) csr_prdata = {28'd0, active_ff};
      else if (csr_paddr == {REG_TOLERANCE, 2'b00}) csr_prdata = {1'b0, tol_ff};
   end

   // Unpack the item.
   always_comb begin
      in_item.is_load  = 1'b0;
      in_item.axis     = req_tuser;
      in_item.cell_idx = req_tdata[11:0];
      in_item.pole     = req_tdata[14:12];
      in_item.w1       = req_tdata[46:15];
      in_item.w2       = req_tdata[78:47];
      in_item.wf       = req_tdata[110:79];
      in_item.flux     = req_tdata[142:111];
      in_item.field    = req_tdata[174:143];
      in_item.eps      = req_tdata[206:175];
   end

   apu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item)
   );

   apu_back #(.MAX_POLES(MAX_POLES), .CELL_COUNT(CELL_COUNT)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_item       (q_item),
      .active_poles (active_ff),
      .tolerance    (tol_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_field    (field),
      .out_disp     (disp),
      .out_fault    (fault)
   );

   assign rsp_tdata = {6'd0, fault, disp, field};

endmodule

/* hdl/apu_front.sv */
// ----------------------------------------------------------------------------
// apu_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module apu_front
   import apu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  item_type       in_item,
   output logic           q_valid,
   input  logic           q_ready,
   output item_type       q_item
);

   item_type   slot_ff [2];
   item_type   slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   // Classification: mark load items; loads still carry D, E and permittivity.
   always_comb begin
      slot_in         = in_item;
      slot_in.is_load = (in_item.axis == FUNC_LOAD);
   end

   // Queue pointers.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

/* hdl/apu_divider.sv */
// ----------------------------------------------------------------------------
// apu_divider
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero, with saturation of the result to 32 bits.
// ----------------------------------------------------------------------------
module apu_divider
   import apu_pkg::*;
#(
   parameter int NUM_W = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] numer,
   input  logic signed [31:0]      denom,
   output logic                    done,
   output logic signed [31:0]      quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  q_ff, q_in;
   logic [32:0]       r_ff, r_in;
   logic [31:0]       d_ff, d_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [33:0]       trial;
   logic [NUM_W:0]    mag;
   logic [NUM_W:0]    sq;

   // Magnitudes at start, then one shift-subtract step a cycle.
   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         q_in    = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
         d_in    = denom[31] ? 32'(-denom) : 32'(denom);
         neg_in  = numer[NUM_W-1] ^ denom[31];
         r_in    = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff, q_ff[NUM_W-1]} - {2'b00, d_ff};
         if (!trial[33]) begin
            r_in = trial[32:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[31:0], q_ff[NUM_W-1]};
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   // Sign and saturation of the quotient.
   always_comb begin
      mag = {1'b0, q_ff};
      sq  = neg_ff ? -mag : mag;
      if (!neg_ff && (q_ff > NUM_W'(32'h7FFF_FFFF))) begin
         quot = 32'sh7FFF_FFFF;
      end else if (neg_ff && (q_ff > NUM_W'(33'h0_8000_0000))) begin
         quot = 32'sh8000_0000;
      end else begin
         quot = sq[31:0];
      end
   end

   assign done = done_ff;

endmodule

/* hdl/apu_back.sv */
// ----------------------------------------------------------------------------
// apu_back
// Executes queued items: weight loads, the per-pole recursion over the
// coefficient and history memories, and the final division.
// ----------------------------------------------------------------------------
module apu_back
   import apu_pkg::*;
#(
   parameter int MAX_POLES  = 8,
   parameter int CELL_COUNT = 4096
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   output logic           q_ready,
   input  item_type       q_item,
   input  logic [3:0]     active_poles,
   input  logic [30:0]    tolerance,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [31:0]    out_field,
   output logic           out_disp,
   output logic           out_fault
);

   localparam int POLE_W  = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;
   localparam int CELL_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int WDEPTH  = MAX_POLES * CELL_COUNT;
   localparam int HDEPTH  = 3 * WDEPTH;
   localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int HADDR_W = $clog2(HDEPTH);
   localparam int ACC_W   = 40;
   localparam int NUM_W   = ACC_W + 16;

   logic [31:0] w1_mem [WDEPTH];
   logic [31:0] w2_mem [WDEPTH];
   logic [31:0] wf_mem [WDEPTH];
   logic [31:0] p1_mem [HDEPTH];
   logic [31:0] p2_mem [HDEPTH];

   back_state_type state_ff, state_in;
   item_type       item_ff;
   logic [POLE_W:0] pole_ff, pole_in;
   logic [HADDR_W-1:0] clr_ff, clr_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic disp_ff, disp_in;
   logic signed [31:0] rw1_ff, rw2_ff, rwf_ff, rp1_ff, rp2_ff;
   logic signed [63:0] m1_ff, m2_ff, m3_ff;
   logic signed [31:0] pol_ff;
   logic [31:0] res_ff;
   logic        res_disp_ff;
   logic        fault_ff;
   logic        valid_ff;
   logic [POLE_W:0] npoles;
   logic [CELL_W-1:0] cell_wrap;
   logic [WADDR_W-1:0] waddr, laddr;
   logic [HADDR_W-1:0] haddr;
   logic signed [49:0] sum;
   logic        take, div_start, div_done;
   logic signed [31:0] div_q;
   logic signed [NUM_W-1:0] numer;
   logic        eps_zero;

   // Address arithmetic: cell wraps modulo the grid size.
   always_comb begin
      cell_wrap = CELL_W'(item_ff.cell_idx % CELL_COUNT);
      waddr = WADDR_W'(pole_ff) * WADDR_W'(CELL_COUNT) + WADDR_W'(cell_wrap);
      haddr = HADDR_W'(item_ff.axis) * HADDR_W'(WDEPTH) + HADDR_W'(waddr);
      laddr = WADDR_W'(q_item.pole) * WADDR_W'(CELL_COUNT)
            + WADDR_W'(CELL_W'(q_item.cell_idx % CELL_COUNT));
      npoles = (32'(active_poles) > MAX_POLES) ? (POLE_W+1)'(MAX_POLES)
                                               : (POLE_W+1)'(active_poles);
      sum = 50'(m1_ff >>> 16) + 50'(m2_ff >>> 16) + 50'(m3_ff >>> 16);
      eps_zero = (item_ff.eps == 32'd0);
      numer = NUM_W'(acc_ff) <<< 16;
   end

   assign take    = (state_ff == ST_IDLE) && q_valid && (!valid_ff || out_ready);
   assign q_ready = take;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == HADDR_W'(HDEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (take && !q_item.is_load) begin
               state_in = (npoles == '0) ? ST_DIV_START : ST_READ;
            end
         end
         ST_READ:      state_in = ST_MUL;
         ST_MUL:       state_in = ST_SUM;
         ST_SUM:       state_in = ST_ACC;
         ST_ACC:       state_in = (pole_ff + 1'b1 == npoles) ? ST_DIV_START : ST_READ;
         ST_DIV_START: state_in = eps_zero ? ST_DONE : ST_DIV;
         ST_DIV:       if (div_done) state_in = ST_DONE;
         ST_DONE:      if (!valid_ff || out_ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath controls.
   always_comb begin
      pole_in   = pole_ff;
      clr_in    = clr_ff;
      acc_in    = acc_ff;
      disp_in   = disp_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         ST_IDLE: begin
            pole_in = '0;
            acc_in  = ACC_W'($signed(q_item.flux));
            disp_in = 1'b0;
         end
         ST_ACC: begin
            acc_in  = acc_ff - ACC_W'(pol_ff);
            pole_in = pole_ff + 1'b1;
            if (rwf_ff > $signed({2'b00, tolerance})) disp_in = 1'b1;
         end
         ST_DIV_START: div_start = !eps_zero;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (state_ff == ST_DONE && (!valid_ff || out_ready)) valid_ff <= 1'b1;
         else if (take && q_item.is_load) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
      end
   end

   // Item and datapath registers; the result fields hold while a result waits.
   always_ff @(posedge clock) begin
      pole_ff <= pole_in;
      acc_ff  <= acc_in;
      disp_ff <= disp_in;
      if (take) item_ff <= q_item;
      m1_ff   <= rw1_ff * rp1_ff;
      m2_ff   <= rw2_ff * rp2_ff;
      m3_ff   <= rwf_ff * $signed(item_ff.field);
      if (state_ff == ST_SUM) begin
         if (sum > 50'sh7FFF_FFFF) pol_ff <= 32'sh7FFF_FFFF;
         else if (sum < -50'sh8000_0000) pol_ff <= 32'sh8000_0000;
         else pol_ff <= sum[31:0];
      end
      if (take && q_item.is_load) begin
         res_ff      <= '0;
         fault_ff    <= 1'b0;
         res_disp_ff <= 1'b0;
      end else if (state_ff == ST_DONE && (!valid_ff || out_ready)) begin
         res_ff      <= eps_zero ? 32'd0 : div_q;
         fault_ff    <= eps_zero;
         res_disp_ff <= disp_ff;
      end
   end

   // Coefficient memories: written by loads, read one pole per pass.
   always_ff @(posedge clock) begin
      if (take && q_item.is_load && (32'(q_item.pole) < MAX_POLES)) begin
         w1_mem[laddr] <= q_item.w1;
         w2_mem[laddr] <= q_item.w2;
         wf_mem[laddr] <= q_item.wf;
      end
      rw1_ff <= w1_mem[waddr];
      rw2_ff <= w2_mem[waddr];
      rwf_ff <= wf_mem[waddr];
   end

   // History memories: cleared after reset, shifted after each pole.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         p1_mem[clr_ff] <= '0;
         p2_mem[clr_ff] <= '0;
      end else if (state_ff == ST_ACC) begin
         p1_mem[haddr] <= pol_ff;
         p2_mem[haddr] <= rp1_ff;
      end
      rp1_ff <= p1_mem[haddr];
      rp2_ff <= p2_mem[haddr];
   end

   apu_divider #(.NUM_W(NUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer),
      .denom (item_ff.eps),
      .done  (div_done),
      .quot  (div_q)
   );

   assign out_valid = valid_ff;
   assign out_field = res_ff;
   assign out_disp  = res_disp_ff;
   assign out_fault = fault_ff;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Dispersive polarization update testbench
// Drives load and update items with random gaps, varies the pole count and
// the tolerance, and checks every result against a predictor that keeps its
// own copy of the weight and history memories.
// ----------------------------------------------------------------------------
module testbench;
   import apu_pkg::*;

   localparam int NUM_POLES  = 8;
   localparam int NUM_CELLS  = 4096;
   localparam int IDLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1150;

   typedef struct {
      logic [1:0]         func;
      logic [11:0]        cell_idx;
      logic [2:0]         pole;
      logic signed [31:0] w1;
      logic signed [31:0] w2;
      logic signed [31:0] wf;
      logic signed [31:0] flux;
      logic signed [31:0] field;
      logic signed [31:0] eps;
   } field_item_type;

   typedef struct {
      logic signed [31:0] new_field;
      logic               dispersive;
      logic               fault;
   } field_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [207:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Predictor state.
   int            weight_one [NUM_POLES][NUM_CELLS];
   int            weight_two [NUM_POLES][NUM_CELLS];
   int            weight_fld [NUM_POLES][NUM_CELLS];
   int            pol_prev [3][NUM_POLES][NUM_CELLS];
   int            pol_older [3][NUM_POLES][NUM_CELLS];
   logic [7:0]    loaded_mask [NUM_CELLS];
   int unsigned   pole_count;
   int unsigned   tolerance;
   field_result_type expected_fields [$];
   int            cell_pool [$];

   int error_count;
   int hold_cycles;
   int burst_left;

   ade_polarization_update #(
      .MAX_POLES (NUM_POLES),
      .CELL_COUNT(NUM_CELLS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic longint clamp_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Computes the result of one item and advances the predictor state.
   function automatic field_result_type predict_field(input field_item_type it);
      field_result_type r;
      longint acc, sum, p1, p2, q;
      int unsigned n;
      int c;
      r.new_field  = '0;
      r.dispersive = 1'b0;
      r.fault      = 1'b0;
      c = it.cell_idx;
      if (it.func == FUNC_LOAD) begin
         weight_one[it.pole][c] = it.w1;
         weight_two[it.pole][c] = it.w2;
         weight_fld[it.pole][c] = it.wf;
         return r;
      end
      n = (pole_count > NUM_POLES) ? NUM_POLES : pole_count;
      acc = longint'(it.flux);
      for (int p = 0; p < n; p++) begin
         p1 = pol_prev[it.func][p][c];
         p2 = pol_older[it.func][p][c];
         sum = ((longint'(weight_one[p][c]) * p1) >>> 16)
             + ((longint'(weight_two[p][c]) * p2) >>> 16)
             + ((longint'(weight_fld[p][c]) * longint'(it.field)) >>> 16);
         sum = clamp_word(sum);
         acc -= sum;
         pol_older[it.func][p][c] = int'(p1);
         pol_prev[it.func][p][c]  = int'(sum);
         if (longint'(weight_fld[p][c]) > longint'(tolerance))
            r.dispersive = 1'b1;
      end
      if (it.eps == 0) begin
         r.fault = 1'b1;
      end else begin
         q = (acc * 65536) / longint'(it.eps);
         r.new_field = clamp_word(q);
      end
      return r;
   endfunction

   // Sends one item; stays valid across back-to-back items inside a burst.
   task automatic send_item(input field_item_type it);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.func;
      req_tdata  <= {1'b0, it.eps, it.field, it.flux, it.wf, it.w2, it.w1,
                     it.pole, it.cell_idx};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      if (it.func == FUNC_LOAD)
         loaded_mask[it.cell_idx][it.pole] = 1'b1;
      expected_fields.push_back(predict_field(it));
      burst_left--;
      if (burst_left <= 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 40)
                                           : $urandom_range(0, 4))
            @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
   endtask

   // Stops offering the last item, then waits until every result is back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_fields.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   // Writes one register through the setup and access phases.
   task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
      wait_drained();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == REG_ACTIVE_POLES) pole_count = value[3:0];
      else tolerance = value[30:0];
   endtask

   // Q16.16 value: mostly modest magnitudes, sometimes full range or extremes.
   function automatic logic signed [31:0] pick_value();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k < 5) return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      if (k < 8) return $urandom;
      if (k == 8) return 32'h7FFFFFFF;
      return 32'h80000000;
   endfunction

   function automatic field_item_type make_load(input int c, input int p);
      field_item_type it;
      it = '{default: '0};
      it.func     = FUNC_LOAD;
      it.cell_idx = c;
      it.pole     = p;
      it.w1       = pick_value();
      it.w2       = pick_value();
      it.wf       = pick_value();
      it.flux     = $urandom;
      it.field    = $urandom;
      it.eps      = $urandom;
      return it;
   endfunction

   // Picks a cell whose weights for every active pole are loaded.
   function automatic field_item_type make_update();
      field_item_type it;
      int unsigned n;
      logic [7:0] need;
      it = '{default: '0};
      it.func = $urandom_range(0, 2);
      it.cell_idx = $urandom;
      n = (pole_count > NUM_POLES) ? NUM_POLES : pole_count;
      need = 8'((9'd1 << n) - 1);
      if ((loaded_mask[it.cell_idx] & need) != need)
         it.cell_idx = cell_pool[$urandom_range(0, cell_pool.size() - 1)];
      it.pole  = $urandom;
      it.w1    = $urandom;
      it.w2    = $urandom;
      it.wf    = $urandom;
      it.flux  = pick_value();
      it.field = pick_value();
      case ($urandom_range(0, 9))
         0:       it.eps = '0;
         1:       it.eps = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
         2:       it.eps = $urandom;
         default: it.eps = $signed($urandom_range(32'h8000, 32'h40000))
                           * ($urandom_range(0, 1) ? 1 : -1);
      endcase
      return it;
   endfunction

   // Loads every pole of a pool of cells so that updates may read them.
   task automatic test_preload();
      cell_pool = '{0, 4095};
      for (int b = 0; b < 12; b++) cell_pool.push_back(1 << b);
      repeat (10) cell_pool.push_back($urandom_range(0, NUM_CELLS - 1));
      foreach (cell_pool[i])
         for (int p = 0; p < NUM_POLES; p++)
            send_item(make_load(cell_pool[i], p));
   endtask

   // Extremes of the fields, every function and the special cases.
   task automatic test_directed();
      field_item_type it;
      logic signed [31:0] vals [4];
      vals = '{32'h7FFFFFFF, 32'h80000000, 32'sd65536, -32'sd1};
      write_reg(REG_ACTIVE_POLES, 32'd8);
      write_reg(REG_TOLERANCE, 32'd0);
      for (int i = 0; i < 12; i++) begin
         it = make_update();
         it.func     = i % 3;
         it.cell_idx = (i < 6) ? 12'd4095 : 12'd0;
         it.flux     = vals[i % 4];
         it.field    = vals[(i + 1) % 4];
         it.eps      = (i == 3 || i == 7) ? 32'sd0 : vals[(i + 2) % 4];
         send_item(it);
      end
      // Load with extreme weights on the top pole, then use them.
      it = make_load(4095, 7);
      it.w1 = 32'h80000000;
      it.w2 = 32'h7FFFFFFF;
      it.wf = 32'h80000000;
      send_item(it);
      it = make_load(0, 7);
      it.w1 = 32'h7FFFFFFF;
      it.w2 = 32'h80000000;
      it.wf = 32'h7FFFFFFF;
      send_item(it);
      for (int i = 0; i < 6; i++) begin
         it = make_update();
         it.cell_idx = (i % 2) ? 12'd0 : 12'd4095;
         it.field    = vals[i % 4];
         it.eps      = 32'sd1;
         send_item(it);
      end
   endtask

   // Pole count above the maximum, none, and the widest tolerance.
   task automatic test_config_extremes();
      write_reg(REG_ACTIVE_POLES, 32'd15);
      write_reg(REG_TOLERANCE, 32'h7FFFFFFF);
      repeat (4) send_item(make_update());
      write_reg(REG_ACTIVE_POLES, 32'd0);
      repeat (4) send_item(make_update());
      write_reg(REG_ACTIVE_POLES, 32'd1);
      write_reg(REG_TOLERANCE, 32'h0000FFFF);
      repeat (4) send_item(make_update());
   endtask

   // Receiver holds off for a long stretch so the input queue fills.
   task automatic test_backpressure();
      write_reg(REG_ACTIVE_POLES, 32'd3);
      hold_cycles = 3000;
      burst_left  = 1000;
      repeat (30) begin
         if ($urandom_range(0, 1)) send_item(make_update());
         else send_item(make_load(cell_pool[$urandom_range(0, cell_pool.size() - 1)],
                                  $urandom_range(0, 7)));
      end
   endtask

   // Random mix of loads and updates under changing settings.
   task automatic test_random();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0) begin
            write_reg(REG_ACTIVE_POLES, $urandom_range(0, 15));
            write_reg(REG_TOLERANCE, ($urandom_range(0, 1) ? $urandom_range(0, 32'h30000)
                                                            : $urandom) & 32'h7FFFFFFF);
         end
         if ($urandom_range(0, 3) == 0)
            send_item(make_load($urandom_range(0, 1) ? $urandom_range(0, NUM_CELLS - 1)
                                : cell_pool[$urandom_range(0, cell_pool.size() - 1)],
                                $urandom_range(0, 7)));
         else
            send_item(make_update());
      end
   endtask

   // Receiver: long hold-offs on request, else a stall pattern that changes.
   initial begin
      int mode;
      int span;
      mode = 0;
      span = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (span <= 0) begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(50, 400);
         end
         span--;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      field_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_fields.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            exp_r = expected_fields.pop_front();
            if (rsp_tdata[31:0] !== exp_r.new_field)
               report_mismatch($sformatf("new_field %h, expected %h",
                                         rsp_tdata[31:0], exp_r.new_field));
            if (rsp_tdata[32] !== exp_r.dispersive)
               report_mismatch($sformatf("cell_dispersive %b, expected %b",
                                         rsp_tdata[32], exp_r.dispersive));
            if (rsp_tdata[33] !== exp_r.fault)
               report_mismatch($sformatf("divide_fault %b, expected %b",
                                         rsp_tdata[33], exp_r.fault));
         end
      end
   end

   // Watchdog on cycles without any accepted item, result or register access.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            idle = 0;
         else
            idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Main sequence.
   initial begin
      error_count = 0;
      hold_cycles = 0;
      burst_left  = 10;
      pole_count  = 0;
      tolerance   = 0;
      foreach (loaded_mask[i]) loaded_mask[i] = '0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_preload();
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random();

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_fields.size() == 0);
      repeat (150) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
hdl/apu_pkg.sv
hdl/apu_front.sv
hdl/apu_divider.sv
hdl/apu_back.sv
hdl/ade_polarization_update.sv
tb/testbench.sv
